/* rtl/hcs_pkg.sv */
package hcs_pkg;

   // fixed field and datapath widths
   localparam int InW       = 16;
   localparam int DegW      = 9;
   localparam int SectorW   = 3;
   localparam int TurnW     = 32;
   localparam int QuarterW  = TurnW - 2;
   localparam int ZW        = TurnW + 1;
   localparam int ScaledW   = 60;
   localparam int CordicW   = ScaledW + 3;
   localparam int MaxStages = 24;
   localparam int DegPerTurn = 360;

   // quadrant of the vector before the stages run
   typedef enum logic [1:0] {
      QUAD_FIRST  = 2'd0,
      QUAD_SECOND = 2'd1,
      QUAD_THIRD  = 2'd2,
      QUAD_FOURTH = 2'd3
   } hcs_quad_type;

   // compass sector codes
   localparam logic [SectorW-1:0] SectorNorth     = 3'd0;
   localparam logic [SectorW-1:0] SectorNortheast = 3'd1;
   localparam logic [SectorW-1:0] SectorEast      = 3'd2;
   localparam logic [SectorW-1:0] SectorSoutheast = 3'd3;
   localparam logic [SectorW-1:0] SectorSouth     = 3'd4;
   localparam logic [SectorW-1:0] SectorSouthwest = 3'd5;
   localparam logic [SectorW-1:0] SectorWest      = 3'd6;
   localparam logic [SectorW-1:0] SectorNorthwest = 3'd7;

   // sector bounds in degrees
   localparam logic [DegW-1:0] BoundNortheast = 9'd23;
   localparam logic [DegW-1:0] BoundEast      = 9'd68;
   localparam logic [DegW-1:0] BoundSoutheast = 9'd113;
   localparam logic [DegW-1:0] BoundSouth     = 9'd158;
   localparam logic [DegW-1:0] BoundSouthwest = 9'd203;
   localparam logic [DegW-1:0] BoundWest      = 9'd248;
   localparam logic [DegW-1:0] BoundNorthwest = 9'd293;
   localparam logic [DegW-1:0] BoundNorth     = 9'd338;

   // vector and angle carried down the rotation pipeline
   typedef struct packed {
      logic signed [CordicW-1:0] cx;
      logic signed [CordicW-1:0] cy;
      logic signed [ZW-1:0]      z;
      hcs_quad_type              quad;
      logic                      zero;
   } hcs_vec_type;

   // atan(2^-i) as a fraction of one turn, 2^32 per turn
   function automatic logic [TurnW-1:0] atan_turn(input int idx);
      logic [TurnW-1:0] value;
      case (idx)
         0:       value = 32'd536870912;
         1:       value = 32'd316933406;
         2:       value = 32'd167458907;
         3:       value = 32'd85004756;
         4:       value = 32'd42667331;
         5:       value = 32'd21354465;
         6:       value = 32'd10679838;
         7:       value = 32'd5340245;
         8:       value = 32'd2670163;
         9:       value = 32'd1335087;
         10:      value = 32'd667544;
         11:      value = 32'd333772;
         12:      value = 32'd166886;
         13:      value = 32'd83443;
         14:      value = 32'd41722;
         15:      value = 32'd20861;
         16:      value = 32'd10430;
         17:      value = 32'd5215;
         18:      value = 32'd2608;
         19:      value = 32'd1304;
         20:      value = 32'd652;
         21:      value = 32'd326;
         22:      value = 32'd163;
         23:      value = 32'd81;
         default: value = '0;
      endcase
      return value;
   endfunction

   // eight-point sector from whole degrees
   function automatic logic [SectorW-1:0] sector_of(input logic [DegW-1:0] deg);
      logic [SectorW-1:0] code;
      if (deg >= BoundNorth || deg < BoundNortheast) begin
         code = SectorNorth;
      end else if (deg < BoundEast) begin
         code = SectorNortheast;
      end else if (deg < BoundSoutheast) begin
         code = SectorEast;
      end else if (deg < BoundSouth) begin
         code = SectorSoutheast;
      end else if (deg < BoundSouthwest) begin
         code = SectorSouth;
      end else if (deg < BoundWest) begin
         code = SectorSouthwest;
      end else if (deg < BoundNorthwest) begin
         code = SectorWest;
      end else begin
         code = SectorNorthwest;
      end
      return code;
   endfunction

endpackage

/* rtl/compass_heading_sector_core.sv */
// channel  | ports          | tdata fields (low bit first)
// req      | req_t*  (in)   | x_component[15:0], y_component[31:16]
// rsp      | rsp_t*  (out)  | heading_degrees[8:0], compass_sector[11:9], zero fill
//
// one item per cycle while rsp_tready is high; CORDIC_STAGES rotation stages (capped at 24):
// input register, one register per rotation stage, then clamp, multiply and sector stages
// reset clears every valid bit; the data registers are not reset
// each stage holds its item while the next cannot take it, so bubbles close up under a stall
// and req_tready drops only when every stage holds an item
module compass_heading_sector_core #(
   parameter int SAMPLE_WIDTH  = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // x_component[15:0], y_component[31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // heading_degrees[8:0], compass_sector[11:9]
);

   localparam int CW         = hcs_pkg::CordicW;
   localparam int TW         = hcs_pkg::TurnW;
   localparam int QW         = hcs_pkg::QuarterW;
   localparam int DW         = hcs_pkg::DegW;
   localparam int IW         = hcs_pkg::InW;
   localparam int PW         = TW + DW;
   localparam int NUM_STAGES = (CORDIC_STAGES > hcs_pkg::MaxStages) ?
                               hcs_pkg::MaxStages : CORDIC_STAGES;
   localparam int GUARD_BITS = hcs_pkg::ScaledW - SAMPLE_WIDTH;
   localparam int RAW_W      = (SAMPLE_WIDTH > IW) ? SAMPLE_WIDTH : IW;

   // input sample extraction and scaling
   logic [RAW_W-1:0]               x_raw;
   logic [RAW_W-1:0]               y_raw;
   logic signed [SAMPLE_WIDTH-1:0] x_smp;
   logic signed [SAMPLE_WIDTH-1:0] y_smp;
   logic signed [CW-1:0]           x_ext;
   logic signed [CW-1:0]           y_ext;
   logic                           x_neg;
   logic                           y_neg;
   logic                           x_nz;
   logic                           y_nz;
   hcs_pkg::hcs_vec_type           prep_in;
   hcs_pkg::hcs_vec_type           prep_ff;
   logic                           prep_valid_ff;

   // rotation pipeline links
   wire                            stage_valid [NUM_STAGES+1];
   wire                            stage_ready [NUM_STAGES+1];
   wire hcs_pkg::hcs_vec_type      stage_data  [NUM_STAGES+1];
   logic [NUM_STAGES:0]            stage_valid_vec;

   // post stages
   hcs_pkg::hcs_vec_type           last_vec;
   logic [QW-1:0]                  z_clamped;
   logic [TW-1:0]                  turn_in;
   logic [TW-1:0]                  turn_ff;
   logic                           turn_zero_ff;
   logic                           turn_valid_ff;
   logic                           turn_ready;
   logic [PW-1:0]                  product;
   logic [DW-1:0]                  deg_in;
   logic [DW-1:0]                  deg_ff;
   logic                           deg_valid_ff;
   logic                           deg_ready;
   logic [DW-1:0]                  heading_ff;
   logic [hcs_pkg::SectorW-1:0]    sector_ff;
   logic                           rsp_valid_ff;
   logic                           rsp_ready_ok;

   // sign-extend the low SAMPLE_WIDTH bits and scale to the working width
   always_comb begin
      x_raw = RAW_W'(req_tdata[IW-1:0]);
      y_raw = RAW_W'(req_tdata[2*IW-1:IW]);
      x_smp = signed'(x_raw[SAMPLE_WIDTH-1:0]);
      y_smp = signed'(y_raw[SAMPLE_WIDTH-1:0]);
      x_ext = CW'(x_smp) <<< GUARD_BITS;
      y_ext = CW'(y_smp) <<< GUARD_BITS;
      x_neg = x_ext[CW-1];
      y_neg = y_ext[CW-1];
      x_nz  = |x_ext;
      y_nz  = |y_ext;
   end

   // fold the vector into the first quadrant
   always_comb begin
      prep_in.z    = '0;
      prep_in.zero = !x_nz && !y_nz;
      if (!x_neg && x_nz && !y_neg) begin
         prep_in.quad = hcs_pkg::QUAD_FIRST;
         prep_in.cx   = x_ext;
         prep_in.cy   = y_ext;
      end else if ((x_neg || !x_nz) && !y_neg && y_nz) begin
         prep_in.quad = hcs_pkg::QUAD_SECOND;
         prep_in.cx   = y_ext;
         prep_in.cy   = -x_ext;
      end else if (x_neg && (y_neg || !y_nz)) begin
         prep_in.quad = hcs_pkg::QUAD_THIRD;
         prep_in.cx   = -x_ext;
         prep_in.cy   = -y_ext;
      end else begin
         prep_in.quad = hcs_pkg::QUAD_FOURTH;
         prep_in.cx   = -y_ext;
         prep_in.cy   = x_ext;
      end
   end

   // input register
   assign req_tready = !prep_valid_ff || stage_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (req_tready) begin
         prep_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         prep_ff <= prep_in;
      end
   end

   assign stage_valid[0] = prep_valid_ff;
   assign stage_data[0]  = prep_ff;

   // rotation stages
   for (genvar gi = 0; gi < NUM_STAGES; gi++) begin : g_stage
      hcs_cordic_stage #(
         .STAGE_INDEX (gi)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .src_valid (stage_valid[gi]),
         .src_ready (stage_ready[gi]),
         .src_data  (stage_data[gi]),
         .dst_valid (stage_valid[gi+1]),
         .dst_ready (stage_ready[gi+1]),
         .dst_data  (stage_data[gi+1])
      );
   end

   for (genvar gv = 0; gv <= NUM_STAGES; gv++) begin : g_valid_vec
      assign stage_valid_vec[gv] = stage_valid[gv];
   end

   // hold the angle inside the quadrant and add the quadrant base
   always_comb begin
      last_vec = stage_data[NUM_STAGES];
      if (last_vec.z[hcs_pkg::ZW-1]) begin
         z_clamped = '0;
      end else if (|last_vec.z[hcs_pkg::ZW-2:QW]) begin
         z_clamped = '1;
      end else begin
         z_clamped = last_vec.z[QW-1:0];
      end
      turn_in = {last_vec.quad, z_clamped};
   end

   assign turn_ready             = !turn_valid_ff || deg_ready;
   assign stage_ready[NUM_STAGES] = turn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_valid_ff <= 1'b0;
      end else if (turn_ready) begin
         turn_valid_ff <= stage_valid[NUM_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (turn_ready && stage_valid[NUM_STAGES]) begin
         turn_ff      <= turn_in;
         turn_zero_ff <= last_vec.zero;
      end
   end

   // turn fraction to whole degrees
   always_comb begin
      product = PW'(turn_ff) * PW'(hcs_pkg::DegPerTurn);
      deg_in  = turn_zero_ff ? '0 : product[PW-1:TW];
   end

   assign deg_ready = !deg_valid_ff || rsp_ready_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         deg_valid_ff <= 1'b0;
      end else if (deg_ready) begin
         deg_valid_ff <= turn_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (deg_ready && turn_valid_ff) begin
         deg_ff <= deg_in;
      end
   end

   // sector lookup and output register
   assign rsp_ready_ok = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_ready_ok) begin
         rsp_valid_ff <= deg_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ready_ok && deg_valid_ff) begin
         heading_ff <= deg_ff;
         sector_ff  <= hcs_pkg::sector_of(deg_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, sector_ff, heading_ff};

   // a synchronous reset empties the output stage
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("output valid after reset");

   // headings stay below a full turn
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (heading_ff <= 9'd359))
      else $error("heading out of range");

   // headings near the top of the circle map to north
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (heading_ff < hcs_pkg::BoundNortheast ||
                      heading_ff >= hcs_pkg::BoundNorth))
      |-> (sector_ff == hcs_pkg::SectorNorth))
      else $error("north sector mismatch");

   // input back-pressure only with a full pipeline and a stalled output
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> ((&stage_valid_vec) && turn_valid_ff && deg_valid_ff &&
                       rsp_tvalid && !rsp_tready))
      else $error("input stalled with room in the pipeline");

endmodule

/* rtl/hcs_cordic_stage.sv */
module hcs_cordic_stage #(
   parameter int STAGE_INDEX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                src_valid,
   output logic                src_ready,
   input  hcs_pkg::hcs_vec_type src_data,
   output logic                dst_valid,
   input  logic                dst_ready,
   output hcs_pkg::hcs_vec_type dst_data
);

   localparam logic [hcs_pkg::TurnW-1:0] ATAN = hcs_pkg::atan_turn(STAGE_INDEX);

   logic                        valid_ff;
   hcs_pkg::hcs_vec_type        data_ff;
   hcs_pkg::hcs_vec_type        data_in;
   logic signed [hcs_pkg::CordicW-1:0] sx;
   logic signed [hcs_pkg::CordicW-1:0] sy;
   logic signed [hcs_pkg::ZW-1:0]      step_angle;

   // one micro-rotation; a vector already on the axis passes through
   always_comb begin
      sx         = src_data.cx >>> STAGE_INDEX;
      sy         = src_data.cy >>> STAGE_INDEX;
      step_angle = $signed({1'b0, ATAN});
      data_in    = src_data;
      if (src_data.cy != '0) begin
         if (!src_data.cy[hcs_pkg::CordicW-1]) begin
            data_in.cx = src_data.cx + sy;
            data_in.cy = src_data.cy - sx;
            data_in.z  = src_data.z + step_angle;
         end else begin
            data_in.cx = src_data.cx - sy;
            data_in.cy = src_data.cy + sx;
            data_in.z  = src_data.z - step_angle;
         end
      end
   end

   // stage register, advances when empty or when downstream takes its item
   assign src_ready = !valid_ff || dst_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (src_ready) begin
         valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (src_ready && src_valid) begin
         data_ff <= data_in;
      end
   end

   assign dst_valid = valid_ff;
   assign dst_data  = data_ff;

endmodule
